### src/lpts_pkg.sv
`default_nettype none
package lpts_pkg;

    // Input transaction: one packet byte
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in;

    // Output transaction: one timestamp
    typedef struct packed {
        logic [33:0] epoch_seconds;
        logic [19:0] sub_second_us;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic take_byte;
        logic div_load;
        logic div_step;
        logic save_ms;
        logic wrap;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic end_data;
    } t_sts;

    localparam int unsigned PosBits  = 11;
    localparam int unsigned DivBits  = 32;
    localparam int unsigned DivSteps = 2;

    // ceil(2^38 / 1000): exact quotient for any 32-bit dividend after >> 38
    localparam logic [28:0] DIV_MAGIC = 29'd274877907;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_POS  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [7:0] HDR_A5 = 8'hA5;
    localparam logic [7:0] HDR_FF = 8'hFF;
    localparam logic [7:0] HDR_00 = 8'h00;
    localparam logic [7:0] HDR_5A = 8'h5A;
    localparam logic [7:0] HDR_EE = 8'hEE;

    localparam logic [PosBits-1:0] POS_MAX      = 11'd2047;
    localparam logic [PosBits-1:0] POS_DATE_LO  = 11'd36;
    localparam logic [PosBits-1:0] POS_DATE_HI  = 11'd41;
    localparam logic [PosBits-1:0] POS_MICRO_LO = 11'd1200;
    localparam logic [PosBits-1:0] POS_MICRO_HI = 11'd1203;

    localparam logic [10:0] DIVISOR  = 11'd1000;
    localparam logic [11:0] BASE_YEAR = 12'd2000;
    // Days from 0000-03-01 to 1970-01-01, plus one for the 1-based day
    localparam logic [20:0] EPOCH_DAYS = 21'd719469;

    // Days from March 1 to the first of the given 0-based month
    function automatic logic [8:0] f_doy(input logic [3:0] mon0);
        logic [8:0] d;
        case (mon0)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### src/lpts_ctrl.sv
`default_nettype none
module lpts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire lpts_pkg::t_sts i_sts,
    output lpts_pkg::t_cmd     o_cmd
);
    import lpts_pkg::*;

    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_SAVE = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_WRAP = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [4:0] LastStep = 5'(DivSteps - 1);

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_RUN);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_RUN: begin
                o_cmd.take_byte = i_in_valid;
                if (i_in_valid && i_sts.end_data) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LastStep) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.save_ms = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LastStep) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### src/lpts_datapath.sv
`default_nettype none
module lpts_datapath #(
    parameter int unsigned PACKET_BYTES = 1206
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lpts_pkg::t_in  i_in_data,
    input  wire lpts_pkg::t_cmd i_cmd,
    output lpts_pkg::t_sts     o_sts,
    output lpts_pkg::t_out     o_out_data
);
    import lpts_pkg::*;

    localparam logic [PosBits-1:0] LastPos = PosBits'(PACKET_BYTES - 1);

    // ---------------- packet parser ----------------
    logic [PosBits-1:0] r_pos;
    logic [1:0]         r_kind, n_kind;
    logic [7:0]         r_pending [6];
    logic [7:0]         r_stored  [6];
    logic [31:0]        r_micro;
    logic [7:0]         b;
    logic               at_end;
    logic [2:0]         date_idx;
    logic [1:0]         lane;
    logic [PosBits-1:0] date_off;
    logic [PosBits-1:0] micro_off;

    assign b         = i_in_data.packet_byte;
    assign at_end    = i_in_data.last_byte && (r_pos == LastPos);
    assign date_off  = POS_DATE_HI - r_pos;
    assign date_idx  = date_off[2:0];
    assign micro_off = r_pos - POS_MICRO_LO;
    assign lane      = micro_off[1:0];

    assign o_sts.end_data = at_end && (r_kind == KIND_DATA);

    always_comb begin
        n_kind = r_kind;
        if (r_pos == 11'd0) begin
            n_kind = (b == HDR_A5) ? KIND_POS : (b == HDR_FF) ? KIND_DATA : KIND_NONE;
        end else if (r_pos == 11'd1) begin
            if ((r_kind == KIND_POS && b != HDR_FF) || (r_kind == KIND_DATA && b != HDR_EE)) begin
                n_kind = KIND_NONE;
            end
        end else if (r_pos == 11'd2) begin
            if (r_kind == KIND_POS && b != HDR_00) begin
                n_kind = KIND_NONE;
            end
        end else if (r_pos == 11'd3) begin
            if (r_kind == KIND_POS && b != HDR_5A) begin
                n_kind = KIND_NONE;
            end
        end
        if (i_in_data.last_byte) begin
            n_kind = KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_kind <= KIND_NONE;
            for (int i = 0; i < 6; i++) begin
                r_pending[i] <= '0;
                r_stored[i]  <= '0;
            end
        end else if (i_cmd.take_byte) begin
            r_kind <= n_kind;
            if (i_in_data.last_byte) begin
                r_pos <= '0;
            end else if (r_pos < POS_MAX) begin
                r_pos <= r_pos + 11'd1;
            end
            if (r_pos >= POS_DATE_LO && r_pos <= POS_DATE_HI) begin
                r_pending[date_idx] <= b;
            end
            // keep the date of a complete position packet
            if (at_end && r_kind == KIND_POS) begin
                for (int i = 0; i < 6; i++) begin
                    r_stored[i] <= r_pending[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && r_pos >= POS_MICRO_LO && r_pos <= POS_MICRO_HI) begin
            r_micro[8*lane +: 8] <= b;
        end
    end

    // ---------------- divide by 1000, reciprocal multiply ----------------
    // Two steps per pass: the quotient lands first, the remainder follows from it.
    logic [DivBits-1:0] r_dvd;
    logic [22:0]        r_quo;
    logic [9:0]         r_rem;
    logic [22:0]        r_ms;
    logic [9:0]         r_us;
    logic [9:0]         r_msf;
    logic [60:0]        quo_prod;
    logic [DivBits-1:0] rem_full;

    assign quo_prod = 61'(r_dvd) * 61'(DIV_MAGIC);
    assign rem_full = r_dvd - DivBits'(r_quo) * DivBits'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= r_micro;
        end else if (i_cmd.div_step) begin
            r_quo <= quo_prod[60:38];
            r_rem <= rem_full[9:0];
        end else if (i_cmd.save_ms) begin
            r_ms  <= r_quo;
            r_us  <= r_rem;
            r_dvd <= DivBits'(r_quo);
        end
        if (i_cmd.wrap) begin
            r_msf <= (r_ms > 23'd1000) ? r_rem : r_ms[9:0];
        end
    end

    // ---------------- calendar pipeline ----------------
    // The kept date is static while the divider runs, so these stages settle
    // long before the result is taken.
    logic [7:0]  mo_m1;
    logic [15:0] q_prod;
    logic [4:0]  q12;
    logic [7:0]  r12;
    logic [11:0] r_year;
    logic [3:0]  r_mon;
    logic [11:0] r_ya;
    logic [8:0]  r_doy, r_doy2;
    logic [11:0] r_ya2;
    logic [24:0] c_prod;
    logic [4:0]  r_c100;
    logic [19:0] r_y365;
    logic [20:0] days_sum;
    logic [16:0] r_days;
    logic [33:0] r_dsec;
    logic [19:0] r_hms;
    logic [33:0] r_epoch;

    assign mo_m1  = r_stored[4] - 8'd1;
    assign q_prod = 16'(mo_m1) * 16'd171;   // floor(x/12) for x < 256
    assign q12    = q_prod[15:11];
    assign r12    = mo_m1 - 8'(q12) * 8'd12;
    assign c_prod = 25'(r_ya) * 25'd5243;   // floor(y/100) for y < 4096

    assign days_sum = 21'(r_y365) + 21'(r_ya2[11:2]) - 21'(r_c100) + 21'(r_c100[4:2])
                    + 21'(r_doy2) + 21'(r_stored[3]) - EPOCH_DAYS;

    always_ff @(posedge i_clk) begin
        if (r_stored[4] == 8'd0) begin
            r_year <= BASE_YEAR - 12'd1 + 12'(r_stored[5]);
            r_mon  <= 4'd11;
        end else begin
            r_year <= BASE_YEAR + 12'(r_stored[5]) + 12'(q12);
            r_mon  <= r12[3:0];
        end
        // January and February count in the year before
        r_ya   <= (r_mon <= 4'd1) ? r_year - 12'd1 : r_year;
        r_doy  <= f_doy(r_mon);
        r_c100 <= c_prod[23:19];
        r_y365 <= 20'(r_ya) * 20'd365;
        r_ya2  <= r_ya;
        r_doy2 <= r_doy;
        r_days <= days_sum[16:0];
        r_dsec <= 34'(r_days) * 34'd86400;
        r_hms  <= 20'(r_stored[2]) * 20'd3600 + 20'(r_stored[1]) * 20'd60
                + 20'(r_stored[0]);
        r_epoch <= r_dsec + 34'(r_hms);
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data.epoch_seconds <= r_epoch;
            o_out_data.sub_second_us <= 20'(r_msf) * 20'd1000 + 20'(r_us);
        end
    end

endmodule
`default_nettype wire

### src/lidar_packet_timestamp.sv
// Channel  Direction  Handshake                    Payload
// in       receive    i_in_valid / o_in_stall      lpts_pkg::t_in  (one packet byte)
// out      send       o_out_valid / i_out_stall    lpts_pkg::t_out (one timestamp)
//
// One byte is taken per cycle while the input is not stalled.
// After the last byte of a data packet of the right length the input stalls
// through load, two 2-step passes of the reciprocal divide by 1000, save, wrap
// and output load; the stall lasts longer only while a previous timestamp is
// still waiting.
// Reset is synchronous and active low; it clears the parser, the kept date and
// the output valid.
`default_nettype none
module lidar_packet_timestamp #(
    parameter int unsigned PACKET_BYTES = 1206
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lpts_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lpts_pkg::t_out     o_out_data
);
    import lpts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lpts_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

### src/lpts_checker.sv
`default_nettype none
module lpts_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire lpts_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire lpts_pkg::t_out o_out_data
);
    import lpts_pkg::*;

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed under stall");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sub_second_us <= 20'd1000999)
        else $error("sub-second field out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // the input stalls only after taking the last byte of a packet
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && i_in_data.last_byte))
        else $error("input stall without a packet end");

endmodule

bind lidar_packet_timestamp lpts_checker u_lpts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
